// ===== hdl/tce_pkg.sv =====
package tce_pkg;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STOP = 8;

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int RN_W   = ROW_W + 1;
	localparam int CN_W   = $clog2(COLUMNS + TAB_STOP);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(CELLS + COLUMNS);
	localparam int N_TABS = (COLUMNS - 1) / TAB_STOP;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	localparam logic [4:0] COLOR_DFLT = 5'h10;

	localparam logic REG_FORE = 1'b0;
	localparam logic REG_BACK = 1'b1;

	typedef enum logic [2:0] {
		OP_TTY    = 3'd0,
		OP_PLACE  = 3'd1,
		OP_CURSOR = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_DRAIN,
		ST_FILL,
		ST_READ
	} state_t;

	typedef struct packed {
		logic [3:0] fore;
		logic [3:0] back;
	} colors_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [15:0]       wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic             done;
		logic             scrolled;
		logic [7:0]       cell_char;
		logic [7:0]       cell_attr;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} res_t;

	function automatic logic [7:0] make_attr(input logic [4:0] fore, input logic [4:0] back,
		input colors_t dflt);
		logic [3:0] f;
		logic [3:0] b;
		f = fore[4] ? dflt.fore : fore[3:0];
		b = back[4] ? dflt.back : back[3:0];
		return {b, f};
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		return ADDR_W'(int'(r) * COLUMNS + int'(c));
	endfunction

	// next tab stop strictly right of c
	function automatic logic [CN_W-1:0] tab_next(input logic [COL_W-1:0] c);
		logic [CN_W-1:0] n;
		n = CN_W'(TAB_STOP);
		for (int k = 1; k <= N_TABS; k++) begin
			if (int'(c) >= k * TAB_STOP)
				n = CN_W'((k + 1) * TAB_STOP);
		end
		return n;
	endfunction

endpackage

// ===== hdl/tce_ram.sv =====
module tce_ram #(
	parameter int DEPTH = 2000,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/tce_ctrl.sv =====
module tce_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        opcode,
	input  logic [7:0]        char_code,
	input  logic [4:0]        fg_code,
	input  logic [4:0]        bg_code,
	input  logic [6:0]        column,
	input  logic [4:0]        row,
	input  tce_pkg::colors_t  dflt,
	input  logic [15:0]       rdata,
	output tce_pkg::mem_req_t mem,
	output tce_pkg::res_t     res,
	output logic              busy
);
	import tce_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              cp_valid_s1;
	logic [CNT_W-1:0]  cp_cnt_s1;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [15:0]       fill_q;
	logic              rd_ok_q;
	logic              done_q, done_d;
	logic              scrolled_q;
	logic [7:0]        cchar_q, cattr_q;

	logic              accept;
	op_t               op;
	logic              in_range;
	logic [ADDR_W-1:0] in_addr;
	logic [7:0]        item_attr;
	logic [15:0]       scroll_blank;

	logic [CN_W-1:0]   tty_col;
	logic              tty_lf, tty_we, tty_wrap, tty_scroll;
	logic [COL_W-1:0]  tty_wcol, tty_col_fin;
	logic [7:0]        tty_char;
	logic [RN_W-1:0]   tty_row;
	logic [ROW_W-1:0]  tty_row_fin;
	logic [COL_W-1:0]  set_col;
	logic [ROW_W-1:0]  set_row;

	assign accept       = start && (state_q == ST_IDLE);
	assign busy         = (state_q != ST_IDLE);
	assign op           = op_t'(opcode);
	assign in_range     = (int'(column) < COLUMNS) && (int'(row) < ROWS);
	assign in_addr      = cell_addr(ROW_W'(row), COL_W'(column));
	assign item_attr    = make_attr(fg_code, bg_code, dflt);
	assign scroll_blank = {make_attr(COLOR_DFLT, COLOR_DFLT, dflt), CH_SPACE};
	assign set_col      = (int'(column) < COLUMNS) ? COL_W'(column) : COL_W'(COLUMNS - 1);
	assign set_row      = (int'(row) < ROWS) ? ROW_W'(row) : ROW_W'(ROWS - 1);

	always_comb begin
		tty_col  = CN_W'(col_q);
		tty_lf   = 1'b0;
		tty_we   = 1'b0;
		tty_wcol = col_q;
		tty_char = char_code;
		case (char_code)
			CH_BS: begin
				if (col_q != '0) begin
					tty_col  = CN_W'(col_q) - CN_W'(1);
					tty_we   = 1'b1;
					tty_wcol = col_q - COL_W'(1);
					tty_char = CH_SPACE;
				end
			end
			CH_TAB: tty_col = tab_next(col_q);
			CH_CR:  tty_col = '0;
			CH_LF: begin
				tty_col = '0;
				tty_lf  = 1'b1;
			end
			default: begin
				if (char_code >= CH_SPACE && char_code <= CH_DEL) begin
					tty_we  = 1'b1;
					tty_col = CN_W'(col_q) + CN_W'(1);
				end
			end
		endcase
		tty_wrap    = (tty_col >= CN_W'(COLUMNS));
		tty_row     = RN_W'(row_q) + RN_W'(tty_lf | tty_wrap);
		tty_scroll  = (tty_row >= RN_W'(ROWS));
		tty_col_fin = tty_wrap ? '0 : COL_W'(tty_col);
		tty_row_fin = tty_scroll ? ROW_W'(ROWS - 1) : ROW_W'(tty_row);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (cnt_q == CNT_W'(CELLS - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (op)
						OP_TTY:   state_d = tty_scroll ? ST_SCROLL : ST_IDLE;
						OP_CLEAR: state_d = ST_FILL;
						OP_READ:  state_d = ST_READ;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCROLL: begin
				if (cnt_q == CNT_W'(CELLS + COLUMNS - 1))
					state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_IDLE;
			ST_FILL: begin
				if (cnt_q == CNT_W'(CELLS - 1))
					state_d = ST_IDLE;
			end
			ST_READ:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory port and completion
	always_comb begin
		mem       = '0;
		mem.raddr = in_addr;
		done_d    = 1'b0;
		case (state_q)
			ST_INIT: begin
				mem.we    = 1'b1;
				mem.waddr = ADDR_W'(cnt_q);
			end
			ST_IDLE: begin
				if (accept) begin
					done_d = 1'b1;
					case (op)
						OP_TTY: begin
							mem.we    = tty_we;
							mem.waddr = cell_addr(row_q, tty_wcol);
							mem.wdata = {item_attr, tty_char};
							done_d    = !tty_scroll;
						end
						OP_PLACE: begin
							mem.we    = in_range;
							mem.waddr = in_addr;
							mem.wdata = {item_attr, char_code};
						end
						OP_CLEAR: done_d = 1'b0;
						OP_READ:  done_d = 1'b0;
						default:  done_d = 1'b1;
					endcase
				end
			end
			ST_SCROLL, ST_DRAIN: begin
				// copy row below up by one; last row takes default blanks
				mem.raddr = ADDR_W'(cnt_q);
				mem.we    = cp_valid_s1;
				mem.waddr = ADDR_W'(cp_cnt_s1 - CNT_W'(COLUMNS));
				mem.wdata = (cp_cnt_s1 < CNT_W'(CELLS)) ? rdata : scroll_blank;
				done_d    = (state_q == ST_DRAIN);
			end
			ST_FILL: begin
				mem.we    = 1'b1;
				mem.waddr = ADDR_W'(cnt_q);
				mem.wdata = fill_q;
				done_d    = (cnt_q == CNT_W'(CELLS - 1));
			end
			ST_READ: done_d = 1'b1;
			default: done_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			cp_valid_s1 <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			cp_valid_s1 <= (state_q == ST_SCROLL);
			done_q      <= done_d;
			if (accept) begin
				cnt_q <= (op == OP_CLEAR) ? '0 : CNT_W'(COLUMNS);
				case (op)
					OP_TTY: begin
						col_q <= tty_col_fin;
						row_q <= tty_row_fin;
					end
					OP_CURSOR: begin
						col_q <= set_col;
						row_q <= set_row;
					end
					OP_CLEAR: begin
						col_q <= '0;
						row_q <= '0;
					end
					default: begin
						col_q <= col_q;
						row_q <= row_q;
					end
				endcase
			end else if (state_q == ST_INIT || state_q == ST_FILL || state_q == ST_SCROLL) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		cp_cnt_s1  <= cnt_q;
		scrolled_q <= (state_q == ST_DRAIN);
		cchar_q    <= (state_q == ST_READ && rd_ok_q) ? rdata[7:0] : 8'h00;
		cattr_q    <= (state_q == ST_READ && rd_ok_q) ? rdata[15:8] : 8'h00;
		if (accept) begin
			fill_q  <= {make_attr(COLOR_DFLT, bg_code, dflt), CH_SPACE};
			rd_ok_q <= in_range;
		end
	end

	assign res.done      = done_q;
	assign res.scrolled  = scrolled_q;
	assign res.cell_char = cchar_q;
	assign res.cell_attr = cattr_q;
	assign res.col       = col_q;
	assign res.row       = row_q;

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(col_q) < COLUMNS) && (int'(row_q) < ROWS))
		else $error("cursor out of range");

	a_read_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_READ |-> ##2 done_q)
		else $error("read beat not returned after two cycles");

	a_clear_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_CLEAR |=> state_q == ST_FILL && cnt_q == '0)
		else $error("clear did not start fill at cell zero");

	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid_s1 && state_q == ST_SCROLL |-> cp_cnt_s1 + CNT_W'(1) == cnt_q)
		else $error("scroll copy stage out of step with read counter");

endmodule

// ===== hdl/text_console_engine.sv =====
// channel   direction  signals                                         handshake
// command   in         opcode char_code fg_code bg_code column row     start && !busy
// result    out        cursor_column cursor_row cursor_addr            done, one cycle
//                      cell_char cell_attr scrolled
// config    in         cfg_index cfg_data                              cfg_we
//
// Teletype (no scroll), place, set cursor and no-op: result in the cycle after the beat is
// taken; read: result after the ST_READ state. Clear writes every cell through the one
// write port, busy until the last cell is written. A scroll copies one cell per cycle up a
// row and blanks the last row, busy through ST_SCROLL and ST_DRAIN before its result.
// After reset a clearing pass writes zero to all CELLS cells (2000), busy until it ends.
// The result strobe cannot be held off; busy is the only stall, on the command side.
module text_console_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [4:0]  fg_code,
	input  logic [4:0]  bg_code,
	input  logic [6:0]  column,
	input  logic [4:0]  row,
	output logic        done,
	output logic [6:0]  cursor_column,
	output logic [4:0]  cursor_row,
	output logic [10:0] cursor_addr,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attr,
	output logic        scrolled,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	import tce_pkg::*;

	colors_t     dflt_q;
	mem_req_t    mem;
	res_t        res;
	logic [15:0] rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q.fore <= 4'hF;
			dflt_q.back <= 4'h0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FORE: dflt_q.fore <= cfg_data;
				REG_BACK: dflt_q.back <= cfg_data;
				default:  dflt_q <= dflt_q;
			endcase
		end
	end

	tce_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.opcode     (opcode),
		.char_code  (char_code),
		.fg_code    (fg_code),
		.bg_code    (bg_code),
		.column     (column),
		.row        (row),
		.dflt       (dflt_q),
		.rdata      (rdata),
		.mem        (mem),
		.res        (res),
		.busy       (busy)
	);

	tce_ram #(
		.DEPTH (CELLS),
		.WIDTH (16)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

	assign done          = res.done;
	assign cursor_column = 7'(res.col);
	assign cursor_row    = 5'(res.row);
	assign cursor_addr   = 11'(cell_addr(res.row, res.col));
	assign cell_char     = res.cell_char;
	assign cell_attr     = res.cell_attr;
	assign scrolled      = res.scrolled;

endmodule
